@@ rtl/core/lcdnw_pkg.sv @@
package lcdnw_pkg;

    // widths of the configuration registers and of the write port
    localparam int EDGE_W      = 16;
    localparam int FIXED_W     = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_DELAY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_WAIT = 1'b1;

    // item kinds on the command channel
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // reset values of the timing registers
    localparam logic [EDGE_W-1:0]  EDGE_DELAY_RST = 16'd50;
    localparam logic [FIXED_W-1:0] FIXED_WAIT_RST = 24'd500000;

    // pin sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_POLL_EH = 4'd1,
        PH_POLL_EL = 4'd2,
        PH_POLL_P1 = 4'd3,
        PH_POLL_P2 = 4'd4,
        PH_POLL_P3 = 4'd5,
        PH_FIXED   = 4'd6,
        PH_HI_SET  = 4'd7,
        PH_HI_PUL  = 4'd8,
        PH_HI_HOLD = 4'd9,
        PH_LO_SET  = 4'd10,
        PH_LO_PUL  = 4'd11,
        PH_LO_HOLD = 4'd12
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       is_data;
        logic       check_busy;
        logic       send_both;
        logic       busy_pin;
    } cmd_item_t;

    typedef struct packed {
        logic       rs_line;
        logic       rw_line;
        logic       enable_line;
        logic [3:0] data_nibble;
        logic       host_drives_bus;
        logic       ready_res;
        logic       start_ignored;
    } res_item_t;

endpackage

@@ rtl/core/lcdnw_ifs.sv @@
// command channel
interface lcdnw_cmd_if
    import lcdnw_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface lcdnw_res_if
    import lcdnw_pkg::*;
();
    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// configuration write channel
interface lcdnw_cfg_if
    import lcdnw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lcdnw_seq.sv @@
module lcdnw_seq
    import lcdnw_pkg::*;
#(
    parameter int DELAY_COUNTER_BITS = 24
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  cmd_item_t          item,
    input  logic [EDGE_W-1:0]  edge_delay,
    input  logic [FIXED_W-1:0] fixed_wait,
    output res_item_t          result
);

    localparam int CW = DELAY_COUNTER_BITS;
    localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      byte_reg, byte_next;
    logic            rsel_reg, rsel_next;
    logic            both_reg, both_next;
    logic            busy_reg, busy_next;
    logic            rs_pin_reg, rs_pin_next;
    logic [3:0]      nib_reg, nib_next;
    logic [CW-1:0]   count_dec;
    logic [CW-1:0]   edge_load;
    logic            ignored;
    logic            polling;

    // counter load: zero counts as one, too large saturates
    function automatic logic [CW-1:0] load_ticks(input logic [FIXED_W-1:0] t);
        logic [32:0] t_ext;
        t_ext = 33'(t);
        if (t == '0)
            return CW'(1);
        else if (t_ext > CNT_MAX)
            return '1;
        else
            return t_ext[CW-1:0];
    endfunction

    assign edge_load = load_ticks(FIXED_W'(edge_delay));
    assign count_dec = count_reg - CW'(count_reg != '0);

    // next state for one item
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        byte_next   = byte_reg;
        rsel_next   = rsel_reg;
        both_next   = both_reg;
        busy_next   = busy_reg;
        rs_pin_next = rs_pin_reg;
        nib_next    = nib_reg;
        ignored     = 1'b0;
        if (step_en)
        begin
            if (item.mode == MODE_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    byte_next = item.byte_value;
                    rsel_next = item.is_data;
                    both_next = item.send_both;
                    busy_next = 1'b0;
                    if (item.check_busy)
                    begin
                        rs_pin_next = 1'b0;
                        phase_next  = PH_POLL_EH;
                        count_next  = edge_load;
                    end
                    else
                    begin
                        phase_next = PH_FIXED;
                        count_next = load_ticks(fixed_wait);
                    end
                end
                else
                begin
                    ignored = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    count_next = edge_load;
                    unique case (phase_reg)
                        PH_POLL_EH:
                        begin
                            busy_next  = item.busy_pin;
                            phase_next = PH_POLL_EL;
                        end
                        PH_POLL_EL: phase_next = PH_POLL_P1;
                        PH_POLL_P1: phase_next = PH_POLL_P2;
                        PH_POLL_P2: phase_next = PH_POLL_P3;
                        PH_POLL_P3, PH_FIXED:
                        begin
                            if (phase_reg == PH_POLL_P3 && busy_reg)
                            begin
                                phase_next = PH_POLL_EH;
                            end
                            else
                            begin
                                rs_pin_next = rsel_reg;
                                nib_next    = byte_reg[7:4];
                                phase_next  = PH_HI_SET;
                            end
                        end
                        PH_HI_SET: phase_next = PH_HI_PUL;
                        PH_HI_PUL: phase_next = PH_HI_HOLD;
                        PH_HI_HOLD:
                        begin
                            if (both_reg)
                            begin
                                nib_next   = byte_reg[3:0];
                                phase_next = PH_LO_SET;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                            end
                        end
                        PH_LO_SET: phase_next = PH_LO_PUL;
                        PH_LO_PUL: phase_next = PH_LO_HOLD;
                        default:
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    endcase
                end
            end
        end
    end

    // pin levels after the item
    always_comb
    begin
        polling = (phase_next == PH_POLL_EH) || (phase_next == PH_POLL_EL) ||
                  (phase_next == PH_POLL_P1) || (phase_next == PH_POLL_P2) ||
                  (phase_next == PH_POLL_P3);
        result.rs_line         = rs_pin_next;
        result.rw_line         = polling;
        result.enable_line     = (phase_next == PH_POLL_EH) || (phase_next == PH_POLL_P2) ||
                                 (phase_next == PH_HI_PUL) || (phase_next == PH_LO_PUL);
        result.data_nibble     = nib_next;
        result.host_drives_bus = !polling;
        result.ready_res       = (phase_next == PH_IDLE);
        result.start_ignored   = ignored;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            byte_reg   <= '0;
            rsel_reg   <= 1'b0;
            both_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            rs_pin_reg <= 1'b0;
            nib_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            byte_reg   <= byte_next;
            rsel_reg   <= rsel_next;
            both_reg   <= both_next;
            busy_reg   <= busy_next;
            rs_pin_reg <= rs_pin_next;
            nib_reg    <= nib_next;
        end
    end

endmodule

@@ rtl/core/char_lcd_nibble_writer.sv @@
// Character LCD writer for a 4-bit HD44780-style bus. Each command item is
// either a tick (one time step of the pin sequencer) or a start that latches
// a byte and its options; every item returns exactly one result holding the
// pin levels after it. An item is registered on entry, runs through the
// sequencer's next-state logic and lands in a result register, so a new
// item is taken every clock cycle while the result channel does not stall;
// only a stalled result channel slows the flow. Timing registers: index 0
// sets the E setup/hold gap in ticks, index 1 the fixed wait used when busy
// polling is off; write them only while idle.
module char_lcd_nibble_writer
    import lcdnw_pkg::*;
#(
    parameter int DELAY_COUNTER_BITS = 24
)(
    input logic         clk,
    input logic         rst_n,
    lcdnw_cmd_if.sink   cmd,
    lcdnw_res_if.source res,
    lcdnw_cfg_if.sink   cfg
);

    logic               in_v_reg;
    cmd_item_t          in_item_reg;
    logic               out_v_reg;
    res_item_t          out_item_reg;
    logic [EDGE_W-1:0]  edge_delay_reg;
    logic [FIXED_W-1:0] fixed_wait_reg;
    logic               advance;
    logic               step_en;
    res_item_t          seq_result;

    assign advance   = !out_v_reg || res.ready;
    assign step_en   = in_v_reg && advance;
    assign cmd.ready = !in_v_reg || advance;
    assign cfg.ready = 1'b1;
    assign res.valid = out_v_reg;
    assign res.data  = out_item_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_delay_reg <= EDGE_DELAY_RST;
            fixed_wait_reg <= FIXED_WAIT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_EDGE_DELAY)
                edge_delay_reg <= cfg.data[EDGE_W-1:0];
            else if (cfg.index == REG_FIXED_WAIT)
                fixed_wait_reg <= cfg.data[FIXED_W-1:0];
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (cmd.ready)
            in_v_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_item_reg <= cmd.data;
    end

    lcdnw_seq #(
        .DELAY_COUNTER_BITS (DELAY_COUNTER_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .item       (in_item_reg),
        .edge_delay (edge_delay_reg),
        .fixed_wait (fixed_wait_reg),
        .result     (seq_result)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_item_reg <= seq_result;
    end

    // checks
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_item_reg.ready_res |-> !out_item_reg.enable_line &&
            !out_item_reg.rw_line)
        else $error("idle result shows E high or a read");

    a_bus_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> out_item_reg.host_drives_bus == !out_item_reg.rw_line)
        else $error("bus direction disagrees with rw");

    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_item_reg.start_ignored |-> !out_item_reg.ready_res)
        else $error("refused start reported while ready");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> cmd.ready)
        else $error("input stalled with empty result stage");

endmodule
